### design/quaternion_to_euler_angles_defines.svh
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: assertion macros
// Shared assertion shorthands for the quaternion to Euler angle converter.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define Q2E_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("q2e check failed");

// Next-cycle implication, checked outside reset.
`define Q2E_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("q2e check failed");

`endif

### design/q2e_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: package
// Formats, constants, the arctangent table and the types that move between
// the cells of the converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

   // Input and output formats.
   localparam int INPUT_FRAC_BITS = 14;
   localparam int ANGLE_FRAC_BITS = 13;
   localparam int CORDIC_STAGES   = 16;
   localparam int IN_W            = 16;
   localparam int ROLL_W          = 16;
   localparam int PITCH_W         = 15;
   localparam int PROD_W          = 2 * IN_W;
   localparam int PROD_FRAC       = 2 * INPUT_FRAC_BITS;
   localparam int SUM_W           = PROD_W + 2;
   localparam int S30_W           = 32;
   localparam int MAG_W           = 30;
   localparam int CW              = SUM_W + 3;
   localparam int ZW              = 34;
   localparam int IDX_W           = 5;
   localparam int ROUND_SHIFT     = 30 - ANGLE_FRAC_BITS;

   // Square root unit: 61-bit radicand, one result bit per cell.
   localparam int SQ_W     = 61;
   localparam int SQ_STEPS = 31;
   localparam int ROOT_W   = 31;

   // Angles in Q2.30 and their rounded output values.
   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint PI_Q   = (PI_Q30 + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
   localparam longint HALF_Q = (HALF_PI_Q30 + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;

   // One CORDIC lane: vector, accumulated angle and the zero-result flag.
   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 zero;
   } lane_type;

   // One square root step: remainder and partial root.
   typedef struct packed {
      logic [SQ_W-1:0] v;
      logic [SQ_W-1:0] r;
   } sqrt_type;

   // Roll, yaw and pitch operands carried beside the square root.
   typedef struct packed {
      logic signed [SUM_W-1:0] sr;
      logic signed [SUM_W-1:0] cr;
      logic signed [SUM_W-1:0] sy;
      logic signed [SUM_W-1:0] cy;
      logic signed [S30_W-1:0] s30;
      logic                    sat;
      logic                    neg;
   } side_type;

   // Pitch flags carried beside the CORDIC chain.
   typedef struct packed {
      logic sat;
      logic neg;
   } pflag_type;

   // atan(2^-i) in Q30, truncated.
   function automatic logic signed [ZW-1:0] atan_q30(input logic [IDX_W-1:0] idx);
      logic signed [ZW-1:0] a;
      unique case (idx)
         5'd0:    a = 34'sd843314856;
         5'd1:    a = 34'sd497837829;
         5'd2:    a = 34'sd263043836;
         5'd3:    a = 34'sd133525158;
         5'd4:    a = 34'sd67021686;
         5'd5:    a = 34'sd33543515;
         5'd6:    a = 34'sd16775850;
         5'd7:    a = 34'sd8388437;
         5'd8:    a = 34'sd4194282;
         5'd9:    a = 34'sd2097149;
         5'd10:   a = 34'sd1048575;
         5'd11:   a = 34'sd524287;
         5'd12:   a = 34'sd262143;
         5'd13:   a = 34'sd131071;
         5'd14:   a = 34'sd65535;
         5'd15:   a = 34'sd32767;
         5'd16:   a = 34'sd16383;
         5'd17:   a = 34'sd8191;
         5'd18:   a = 34'sd4095;
         5'd19:   a = 34'sd2047;
         5'd20:   a = 34'sd1023;
         5'd21:   a = 34'sd511;
         5'd22:   a = 34'sd255;
         5'd23:   a = 34'sd127;
         5'd24:   a = 34'sd63;
         5'd25:   a = 34'sd31;
         5'd26:   a = 34'sd15;
         5'd27:   a = 34'sd7;
         5'd28:   a = 34'sd3;
         5'd29:   a = 34'sd1;
         default: a = '0;
      endcase
      return a;
   endfunction

   // Start a vectoring CORDIC: fold a left half-plane vector by -+pi/2.
   function automatic lane_type prerotate(input logic signed [CW-1:0] y,
                                          input logic signed [CW-1:0] x);
      lane_type l;
      l.zero = (y == '0) && !x[CW-1];
      l.x    = x;
      l.y    = y;
      l.z    = '0;
      if (x[CW-1]) begin
         if (!y[CW-1]) begin
            l.x = y;
            l.y = -x;
            l.z = ZW'(HALF_PI_Q30);
         end else begin
            l.x = -y;
            l.y = x;
            l.z = -ZW'(HALF_PI_Q30);
         end
      end
      return l;
   endfunction

   // Round a Q30 angle half up to the output fraction.
   function automatic logic signed [ZW-1:0] to_angle(input logic signed [ZW-1:0] z);
      logic signed [ZW-1:0] t;
      t = z + (ZW'(1) <<< (ROUND_SHIFT - 1));
      return t >>> ROUND_SHIFT;
   endfunction

endpackage

### design/q2e_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: square root cell
// One restoring step of the integer square root; gives one root bit and
// hands remainder and partial root to the next cell.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell (
   input  logic                                 clock,
   input  logic [q2e_pkg::IDX_W-1:0]            step,
   input  q2e_pkg::sqrt_type                    sq_in,
   output q2e_pkg::sqrt_type                    sq_out
);

   q2e_pkg::sqrt_type sq_ff;
   q2e_pkg::sqrt_type sq_in_c;
   logic [q2e_pkg::SQ_W-1:0] bit_val;
   logic [q2e_pkg::SQ_W-1:0] trial;

   // Trial subtraction against the partial root plus the current bit.
   always_comb begin
      bit_val = q2e_pkg::SQ_W'(1) << (q2e_pkg::SQ_W - 1 - 2 * int'(step));
      trial   = sq_in.r + bit_val;
      if (sq_in.v >= trial) begin
         sq_in_c.v = sq_in.v - trial;
         sq_in_c.r = (sq_in.r >> 1) + bit_val;
      end else begin
         sq_in_c.v = sq_in.v;
         sq_in_c.r = sq_in.r >> 1;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff <= sq_in_c;
   end

   assign sq_out = sq_ff;

endmodule

### design/q2e_cordic_cell.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: CORDIC cell
// One vectoring micro-rotation: turns the vector toward the x axis and
// accumulates the matching arctangent.
// ----------------------------------------------------------------------------
module q2e_cordic_cell (
   input  logic                      clock,
   input  logic [q2e_pkg::IDX_W-1:0] step,
   input  q2e_pkg::lane_type         lane_in,
   output q2e_pkg::lane_type         lane_out
);

   q2e_pkg::lane_type lane_ff;
   q2e_pkg::lane_type lane_in_c;
   logic signed [q2e_pkg::CW-1:0] dx;
   logic signed [q2e_pkg::CW-1:0] dy;
   logic signed [q2e_pkg::ZW-1:0] ang;

   // Rotate by the sign of y.
   always_comb begin
      dx  = lane_in.x >>> step;
      dy  = lane_in.y >>> step;
      ang = q2e_pkg::atan_q30(step);
      lane_in_c.zero = lane_in.zero;
      if (!lane_in.y[q2e_pkg::CW-1]) begin
         lane_in_c.x = lane_in.x + dy;
         lane_in_c.y = lane_in.y - dx;
         lane_in_c.z = lane_in.z + ang;
      end else begin
         lane_in_c.x = lane_in.x - dy;
         lane_in_c.y = lane_in.y + dx;
         lane_in_c.z = lane_in.z - ang;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_in_c;
   end

   assign lane_out = lane_ff;

endmodule

### design/quaternion_to_euler_angles.sv
// A request passes the front-end stages, the square root chain (31 cells), the
// pre-rotation register, the three CORDIC chains (16 cells each) and the output
// register. Throughput: one request per cycle outside reset, as all are fully pipelined.
// Reset clears the valid pipeline; busy is high only while reset is high.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: top level
// Converts a Q1.14 quaternion to ZYX roll and yaw in Q2.13 and pitch in Q1.13 radians.
// ----------------------------------------------------------------------------
`include "quaternion_to_euler_angles_defines.svh"

module quaternion_to_euler_angles (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_quat_x,
   input  logic [15:0] req_quat_y,
   input  logic [15:0] req_quat_z,
   input  logic [15:0] req_quat_w,
   output logic        rsp_valid,
   output logic [15:0] rsp_roll_angle,
   output logic [14:0] rsp_pitch_angle,
   output logic [15:0] rsp_yaw_angle,
   output logic        rsp_pitch_saturated
);

   localparam int CW     = q2e_pkg::CW;
   localparam int SUM_W  = q2e_pkg::SUM_W;
   localparam int NCS    = q2e_pkg::CORDIC_STAGES;
   localparam int NSQ    = q2e_pkg::SQ_STEPS;
   localparam int DEPTH  = 5 + NSQ + 1 + NCS + 1;
   localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) <<< q2e_pkg::PROD_FRAC;
   localparam logic signed [q2e_pkg::ZW-1:0] PI_LIM   = q2e_pkg::ZW'(q2e_pkg::PI_Q);
   localparam logic signed [q2e_pkg::ZW-1:0] HALF_LIM = q2e_pkg::ZW'(q2e_pkg::HALF_Q);

   logic [DEPTH-1:0] vld_ff;

   // Stage 1: captured request.
   logic signed [15:0] qx_ff, qy_ff, qz_ff, qw_ff;
   // Stage 2: products.
   logic signed [31:0] wx_ff, yz_ff, xx_ff, yy_ff, wz_ff, xy_ff, zz_ff, wy_ff, zx_ff;
   // Stage 3: sine and cosine terms.
   logic signed [SUM_W-1:0] sr_ff, cr_ff, sy_ff, cy_ff, sp_ff;
   // Stage 4: pitch sine in Q30 and its magnitude.
   logic signed [SUM_W-1:0] sr4_ff, cr4_ff, sy4_ff, cy4_ff;
   logic signed [q2e_pkg::S30_W-1:0] s30_ff;
   logic [q2e_pkg::MAG_W-1:0] mag_ff;
   logic sat4_ff, neg4_ff;
   logic signed [q2e_pkg::S30_W-1:0] s30_in;
   logic [q2e_pkg::S30_W-1:0] abs_in;
   // Stage 5: radicand.
   logic [q2e_pkg::SQ_W-1:0] rad_ff;
   q2e_pkg::side_type side5_ff;

   q2e_pkg::sqrt_type sq_w [0:NSQ];
   q2e_pkg::side_type side_ff [0:NSQ-1];
   q2e_pkg::side_type side_last;

   q2e_pkg::lane_type roll_w  [0:NCS];
   q2e_pkg::lane_type yaw_w   [0:NCS];
   q2e_pkg::lane_type pitch_w [0:NCS];
   q2e_pkg::lane_type roll0_ff, yaw0_ff, pitch0_ff;
   q2e_pkg::pflag_type pf_ff [0:NCS];

   logic signed [q2e_pkg::ZW-1:0] roll_a, yaw_a, pitch_a;
   logic signed [q2e_pkg::ZW-1:0] roll_in, yaw_in, pitch_in;
   logic [15:0] roll_ff, yaw_ff;
   logic [14:0] pitch_ff;
   logic sat_ff;

   // The pipeline never stalls; only reset holds requests off.
   assign busy = reset;

   // Valid bits travel beside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[DEPTH-2:0], start & ~busy};
      end
   end

   // Front end: capture, multiply, sum, pitch magnitude and radicand.
   always_comb begin
      s30_in = q2e_pkg::S30_W'(sp_ff) <<< (30 - q2e_pkg::PROD_FRAC);
      abs_in = s30_in[q2e_pkg::S30_W-1] ? q2e_pkg::S30_W'(-s30_in)
                                        : q2e_pkg::S30_W'(s30_in);
   end

   always_ff @(posedge clock) begin
      qx_ff <= req_quat_x;
      qy_ff <= req_quat_y;
      qz_ff <= req_quat_z;
      qw_ff <= req_quat_w;

      wx_ff <= qw_ff * qx_ff;
      yz_ff <= qy_ff * qz_ff;
      xx_ff <= qx_ff * qx_ff;
      yy_ff <= qy_ff * qy_ff;
      wz_ff <= qw_ff * qz_ff;
      xy_ff <= qx_ff * qy_ff;
      zz_ff <= qz_ff * qz_ff;
      wy_ff <= qw_ff * qy_ff;
      zx_ff <= qz_ff * qx_ff;

      sr_ff <= (SUM_W'(wx_ff) + SUM_W'(yz_ff)) <<< 1;
      cr_ff <= ONE - ((SUM_W'(xx_ff) + SUM_W'(yy_ff)) <<< 1);
      sy_ff <= (SUM_W'(wz_ff) + SUM_W'(xy_ff)) <<< 1;
      cy_ff <= ONE - ((SUM_W'(yy_ff) + SUM_W'(zz_ff)) <<< 1);
      sp_ff <= (SUM_W'(wy_ff) - SUM_W'(zx_ff)) <<< 1;

      sr4_ff  <= sr_ff;
      cr4_ff  <= cr_ff;
      sy4_ff  <= sy_ff;
      cy4_ff  <= cy_ff;
      s30_ff  <= s30_in;
      mag_ff  <= abs_in[q2e_pkg::MAG_W-1:0];
      sat4_ff <= (sp_ff >= ONE) || (sp_ff <= -ONE);
      neg4_ff <= sp_ff[SUM_W-1];

      rad_ff       <= (q2e_pkg::SQ_W'(1) << 60)
                      - q2e_pkg::SQ_W'(mag_ff * mag_ff);
      side5_ff.sr  <= sr4_ff;
      side5_ff.cr  <= cr4_ff;
      side5_ff.sy  <= sy4_ff;
      side5_ff.cy  <= cy4_ff;
      side5_ff.s30 <= s30_ff;
      side5_ff.sat <= sat4_ff;
      side5_ff.neg <= neg4_ff;
   end

   // Square root chain for the pitch cosine; other operands ride beside it.
   assign sq_w[0].v = rad_ff;
   assign sq_w[0].r = '0;

   for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
      q2e_sqrt_cell u_cell (
         .clock  (clock),
         .step   (q2e_pkg::IDX_W'(k)),
         .sq_in  (sq_w[k]),
         .sq_out (sq_w[k+1])
      );
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side5_ff;
      for (int k = 1; k < NSQ; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   assign side_last = side_ff[NSQ-1];

   // Pre-rotation of the three CORDIC lanes.
   always_ff @(posedge clock) begin
      roll0_ff  <= q2e_pkg::prerotate(CW'(side_last.sr), CW'(side_last.cr));
      yaw0_ff   <= q2e_pkg::prerotate(CW'(side_last.sy), CW'(side_last.cy));
      pitch0_ff <= q2e_pkg::prerotate(CW'(side_last.s30),
                                      CW'(sq_w[NSQ].r[q2e_pkg::ROOT_W-1:0]));
      pf_ff[0].sat <= side_last.sat;
      pf_ff[0].neg <= side_last.neg;
      for (int k = 1; k <= NCS; k++) begin
         pf_ff[k] <= pf_ff[k-1];
      end
   end

   assign roll_w[0]  = roll0_ff;
   assign yaw_w[0]   = yaw0_ff;
   assign pitch_w[0] = pitch0_ff;

   // CORDIC chains.
   for (genvar k = 0; k < NCS; k++) begin : g_cordic
      q2e_cordic_cell u_roll (
         .clock    (clock),
         .step     (q2e_pkg::IDX_W'(k)),
         .lane_in  (roll_w[k]),
         .lane_out (roll_w[k+1])
      );
      q2e_cordic_cell u_yaw (
         .clock    (clock),
         .step     (q2e_pkg::IDX_W'(k)),
         .lane_in  (yaw_w[k]),
         .lane_out (yaw_w[k+1])
      );
      q2e_cordic_cell u_pitch (
         .clock    (clock),
         .step     (q2e_pkg::IDX_W'(k)),
         .lane_in  (pitch_w[k]),
         .lane_out (pitch_w[k+1])
      );
   end

   // Round, clamp and select the saturated pitch.
   always_comb begin
      roll_a  = roll_w[NCS].zero  ? '0 : q2e_pkg::to_angle(roll_w[NCS].z);
      yaw_a   = yaw_w[NCS].zero   ? '0 : q2e_pkg::to_angle(yaw_w[NCS].z);
      pitch_a = pitch_w[NCS].zero ? '0 : q2e_pkg::to_angle(pitch_w[NCS].z);

      roll_in = roll_a;
      if (roll_a > PI_LIM) begin
         roll_in = PI_LIM;
      end else if (roll_a < -PI_LIM) begin
         roll_in = -PI_LIM;
      end

      yaw_in = yaw_a;
      if (yaw_a > PI_LIM) begin
         yaw_in = PI_LIM;
      end else if (yaw_a < -PI_LIM) begin
         yaw_in = -PI_LIM;
      end

      pitch_in = pitch_a;
      if (pf_ff[NCS].sat) begin
         pitch_in = pf_ff[NCS].neg ? -HALF_LIM : HALF_LIM;
      end else if (pitch_a > HALF_LIM) begin
         pitch_in = HALF_LIM;
      end else if (pitch_a < -HALF_LIM) begin
         pitch_in = -HALF_LIM;
      end
   end

   always_ff @(posedge clock) begin
      roll_ff  <= roll_in[15:0];
      yaw_ff   <= yaw_in[15:0];
      pitch_ff <= pitch_in[14:0];
      sat_ff   <= pf_ff[NCS].sat;
   end

   assign rsp_valid           = vld_ff[DEPTH-1];
   assign rsp_roll_angle      = roll_ff;
   assign rsp_pitch_angle     = pitch_ff;
   assign rsp_yaw_angle       = yaw_ff;
   assign rsp_pitch_saturated = sat_ff;

   // Checks on the result range and the request pipeline.
   `Q2E_ASSERT_NEXT(a_accept_enters, start && !busy, vld_ff[0])
   `Q2E_ASSERT_IMPL(a_pitch_range, rsp_valid, ($signed(rsp_pitch_angle) <= 15'sd12868) && ($signed(rsp_pitch_angle) >= -15'sd12868))
   `Q2E_ASSERT_IMPL(a_sat_clamped, rsp_valid && rsp_pitch_saturated, ($signed(rsp_pitch_angle) == 15'sd12868) || ($signed(rsp_pitch_angle) == -15'sd12868))
   `Q2E_ASSERT_IMPL(a_roll_range, rsp_valid, ($signed(rsp_roll_angle) <= 16'sd25736) && ($signed(rsp_roll_angle) >= -16'sd25736))

endmodule

### test/quaternion_to_euler_angles_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: testbench
// Drives quaternion requests into the converter and compares roll, pitch, yaw
// and the pitch clamp flag with a bit-exact fixed-point model kept here.
// ----------------------------------------------------------------------------

// Holds the predicted angles of accepted requests and checks the results.
class euler_scoreboard;
   typedef struct {
      logic [15:0] roll;
      logic [14:0] pitch;
      logic [15:0] yaw;
      logic        sat;
   } angles_type;

   angles_type pending_angles[$];
   int unsigned mismatch_count;

   // Arithmetic shift right that rounds toward minus infinity.
   static function longint shift_floor(longint v, int s);
      return v >>> s;
   endfunction

   static function longint round_angle(longint z);
      return shift_floor(z + (64'sd1 <<< (q2e_pkg::ROUND_SHIFT - 1)), q2e_pkg::ROUND_SHIFT);
   endfunction

   static function longint limit(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // Floor of the integer square root.
   static function longint root_floor(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   // Vectoring CORDIC arctangent in Q30.
   static function longint arctan2_q30(longint y, longint x);
      longint acc, tmp, dx, dy;
      acc = 0;
      if (y == 0 && x >= 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            tmp = x; x = y; y = -tmp; acc = q2e_pkg::HALF_PI_Q30;
         end else begin
            tmp = x; x = -y; y = tmp; acc = -q2e_pkg::HALF_PI_Q30;
         end
      end
      for (int i = 0; i < q2e_pkg::CORDIC_STAGES; i++) begin
         dx = shift_floor(x, i);
         dy = shift_floor(y, i);
         if (y >= 0) begin
            x += dy; y -= dx;
            acc += longint'(q2e_pkg::atan_q30(q2e_pkg::IDX_W'(i)));
         end else begin
            x -= dy; y += dx;
            acc -= longint'(q2e_pkg::atan_q30(q2e_pkg::IDX_W'(i)));
         end
      end
      return acc;
   endfunction

   // Work out the angles of one accepted request and store them.
   function void note_request(logic signed [15:0] qx, logic signed [15:0] qy,
                              logic signed [15:0] qz, logic signed [15:0] qw);
      longint x, y, z, w, unity, pi_q, half_q;
      longint sr, cr, sy, cy, sp, s30, c;
      longint unsigned mag;
      angles_type a;
      x = qx; y = qy; z = qz; w = qw;
      unity = 64'sd1 <<< 28;
      pi_q = round_angle(q2e_pkg::PI_Q30);
      half_q = round_angle(q2e_pkg::HALF_PI_Q30);
      sr = 2 * (w * x + y * z);
      cr = unity - 2 * (x * x + y * y);
      sy = 2 * (w * z + x * y);
      cy = unity - 2 * (y * y + z * z);
      sp = 2 * (w * y - z * x);
      a.roll = 16'(limit(round_angle(arctan2_q30(sr, cr)), pi_q));
      a.yaw = 16'(limit(round_angle(arctan2_q30(sy, cy)), pi_q));
      // Pitch sine at or beyond one clamps to a right angle.
      if (sp >= unity || sp <= -unity) begin
         a.pitch = 15'(sp > 0 ? half_q : -half_q);
         a.sat = 1'b1;
      end else begin
         s30 = limit(sp * 4, 64'sd1 <<< 30);
         mag = longint'(s30 < 0 ? -s30 : s30);
         c = root_floor((64'd1 << 60) - mag * mag);
         a.pitch = 15'(limit(round_angle(arctan2_q30(s30, c)), half_q));
         a.sat = 1'b0;
      end
      pending_angles.push_back(a);
   endfunction

   function void check_result(logic [15:0] roll, logic [14:0] pitch,
                              logic [15:0] yaw, logic sat);
      angles_type a;
      if (pending_angles.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10) $display("Unexpected result: roll %h", roll);
         return;
      end
      a = pending_angles.pop_front();
      if (a.roll !== roll || a.pitch !== pitch || a.yaw !== yaw || a.sat !== sat) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("Mismatch: expected %h %h %h %b, got %h %h %h %b",
                     a.roll, a.pitch, a.yaw, a.sat, roll, pitch, yaw, sat);
      end
   endfunction
endclass

module quaternion_to_euler_angles_test;
   localparam int LATENCY = 53;
   localparam int WATCHDOG_LIMIT = 2000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [15:0] req_quat_x, req_quat_y, req_quat_z, req_quat_w;
   logic        rsp_valid;
   logic [15:0] rsp_roll_angle;
   logic [14:0] rsp_pitch_angle;
   logic [15:0] rsp_yaw_angle;
   logic        rsp_pitch_saturated;

   euler_scoreboard angles_board;
   int unsigned idle_cycles;
   bit          calm_stretch;

   quaternion_to_euler_angles u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_quat_x(req_quat_x), .req_quat_y(req_quat_y),
      .req_quat_z(req_quat_z), .req_quat_w(req_quat_w),
      .rsp_valid(rsp_valid), .rsp_roll_angle(rsp_roll_angle),
      .rsp_pitch_angle(rsp_pitch_angle), .rsp_yaw_angle(rsp_yaw_angle),
      .rsp_pitch_saturated(rsp_pitch_saturated)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Note accepted requests and check results at each rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            angles_board.note_request(req_quat_x, req_quat_y, req_quat_z, req_quat_w);
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (rsp_valid)
            angles_board.check_result(rsp_roll_angle, rsp_pitch_angle,
                                      rsp_yaw_angle, rsp_pitch_saturated);
      end
   end

   // Watchdog on cycles with no accepted request.
   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Present one request and hold it until it is taken; start stays high
   // into the next request unless an idle cycle drops it.
   task automatic send_request(logic [15:0] qx, logic [15:0] qy,
                               logic [15:0] qz, logic [15:0] qw);
      if (!calm_stretch) begin
         while ($urandom_range(99) < 8) begin
            start <= 1'b0;
            @(negedge clock);
         end
      end
      start <= 1'b1;
      req_quat_x <= qx; req_quat_y <= qy; req_quat_z <= qz; req_quat_w <= qw;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // Any component: mostly in the Q1.14 range, sometimes any bit pattern.
   function automatic logic [15:0] pick_component();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10) return 16'($urandom);
      if (r < 20) return 16'($urandom_range(1, 0) ? 16384 : -16384);
      return 16'($signed($urandom_range(32768)) - 16384);
   endfunction

   // Unit quaternion from a random direction, built by scaling.
   task automatic send_unit_quaternion();
      real a, b, c, d, n;
      a = $itor($signed($urandom_range(2000)) - 1000);
      b = $itor($signed($urandom_range(2000)) - 1000);
      c = $itor($signed($urandom_range(2000)) - 1000);
      d = $itor($signed($urandom_range(2000)) - 1000);
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) begin
         a = 1000.0; n = 1000.0;
      end
      send_request(16'($rtoi(a / n * 16384.0)), 16'($rtoi(b / n * 16384.0)),
                   16'($rtoi(c / n * 16384.0)), 16'($rtoi(d / n * 16384.0)));
   endtask

   initial begin
      int unsigned wait_cycles;
      angles_board = new();
      idle_cycles = 0;
      calm_stretch = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_quat_x = '0; req_quat_y = '0; req_quat_z = '0; req_quat_w = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: identity, zero, axis turns, gimbal lock and extremes.
      send_request(16'h0000, 16'h0000, 16'h0000, 16'h4000);
      send_request(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_request(16'h4000, 16'h0000, 16'h0000, 16'h0000);
      send_request(16'h0000, 16'h4000, 16'h0000, 16'h0000);
      send_request(16'h0000, 16'h0000, 16'h4000, 16'h0000);
      send_request(16'hC000, 16'h0000, 16'h0000, 16'h0000);
      send_request(16'h0000, 16'h2D41, 16'h0000, 16'h2D41);
      send_request(16'h0000, 16'hD2BF, 16'h0000, 16'h2D41);
      send_request(16'h2D41, 16'h0000, 16'h0000, 16'h2D41);
      send_request(16'h0000, 16'h0000, 16'hD2BF, 16'h2D41);
      send_request(16'h2000, 16'h2000, 16'h2000, 16'h2000);
      send_request(16'hE000, 16'h2000, 16'hE000, 16'h2000);
      send_request(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_request(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_request(16'h8000, 16'h7FFF, 16'h0000, 16'h7FFF);
      send_request(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001);
      send_request(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
      send_request(16'h0000, 16'h0001, 16'h0000, 16'h0000);
      send_request(16'hC000, 16'h0000, 16'h0001, 16'h0000);

      // Random: unit quaternions mostly, raw patterns the rest.
      for (int i = 0; i < 1350; i++) begin
         calm_stretch = (i >= 400 && i < 600);
         if ($urandom_range(99) < 70) send_unit_quaternion();
         else send_request(pick_component(), pick_component(),
                           pick_component(), pick_component());
      end
      start <= 1'b0;

      wait_cycles = 0;
      while (angles_board.pending_angles.size() != 0 && wait_cycles < 10 * LATENCY) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (LATENCY) @(posedge clock);
      if (angles_board.mismatch_count == 0 && angles_board.pending_angles.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
